FILE: design/ape_pkg.sv
// Shared types, constants and helpers of the alternating pulse remote encoder.
package ape_pkg;

   localparam int ID_BITS     = 16;
   localparam int KEY_BITS    = 7;
   localparam int TIMER_WIDTH = 16;
   localparam int FRAME_BITS  = ID_BITS + KEY_BITS;
   localparam int POS_W       = $clog2(FRAME_BITS + 1);
   localparam int REG_W       = 16;
   localparam int REPEAT_W    = 8;
   localparam int CSR_IDX_W   = 2;

   localparam logic OP_TICK  = 1'b0;
   localparam logic OP_START = 1'b1;

   localparam logic [CSR_IDX_W-1:0] CSR_START_TICKS   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SHORT_TICKS   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_LONG_TICKS    = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_REPEATS = 2'd3;

   localparam logic [REG_W-1:0]    START_TICKS_RESET   = 16'd500;
   localparam logic [REG_W-1:0]    SHORT_TICKS_RESET   = 16'd100;
   localparam logic [REG_W-1:0]    LONG_TICKS_RESET    = 16'd300;
   localparam logic [REPEAT_W-1:0] FRAME_REPEATS_RESET = 8'd181;

   typedef struct packed {
      logic                op;
      logic [ID_BITS-1:0]  remote_id;
      logic [KEY_BITS-1:0] keycode;
   } req_type;

   typedef struct packed {
      logic line_level;
      logic busy_res;
      logic accepted;
   } rsp_type;

   typedef struct packed {
      logic                  is_start;
      logic [FRAME_BITS-1:0] frame_word;
   } cmd_type;

   function automatic logic [TIMER_WIDTH-1:0] duration(input logic [REG_W-1:0] value);
      logic [TIMER_WIDTH-1:0] t;
      t = TIMER_WIDTH'(value);
      return (t == '0) ? TIMER_WIDTH'(1) : t;
   endfunction

endpackage

FILE: design/alternating_pulse_remote_encoder_core.sv
// Top level of the alternating pulse remote encoder: front queue and frame sequencer.
//
//   channel  direction  handshake             payload
//   req_     in         req_valid/req_ready   ape_pkg::req_type (op, remote_id, keycode)
//   rsp_     out        rsp_valid/rsp_ready   ape_pkg::rsp_type (line_level, busy_res, accepted)
//   csr_     in         csr_we                csr_index, csr_wdata
//
// One transaction per cycle sustained while results are taken; the edge that pops a request
// from the two-entry front queue loads its result, so a request is queued before its result.
// The sequencer steps one request per cycle whenever the result register is free.
// Synchronous reset loads the default timing registers and leaves the line low and idle.
// A stalled result holds the sequencer; the queue keeps taking requests until full.
module alternating_pulse_remote_encoder_core (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  ape_pkg::req_type              req_data,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output ape_pkg::rsp_type              rsp_data,
   input  logic                          csr_we,
   input  logic [ape_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [ape_pkg::REG_W-1:0]     csr_wdata
);

   logic             cmd_valid;
   logic             cmd_ready;
   ape_pkg::cmd_type cmd;

   ape_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .cmd_valid (cmd_valid),
      .cmd_ready (cmd_ready),
      .cmd       (cmd)
   );

   ape_back u_back (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cmd_valid (cmd_valid),
      .cmd_ready (cmd_ready),
      .cmd       (cmd),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

FILE: design/ape_front.sv
// Front end: accepts request transactions, classifies them and queues commands.
module ape_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  ape_pkg::req_type  req_data,
   output logic              cmd_valid,
   input  logic              cmd_ready,
   output ape_pkg::cmd_type  cmd
);

   ape_pkg::cmd_type queue_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       push, pop;
   ape_pkg::cmd_type entry;

   assign req_ready = (count_ff != 2'd2);
   assign cmd_valid = (count_ff != 2'd0);
   assign cmd       = queue_ff[rd_ptr_ff];
   assign push      = req_valid && req_ready;
   assign pop       = cmd_valid && cmd_ready;

   always_comb begin
      entry.is_start   = (req_data.op == ape_pkg::OP_START);
      entry.frame_word = {req_data.remote_id[ape_pkg::ID_BITS-1:0],
                          req_data.keycode[ape_pkg::KEY_BITS-1:0]};
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

`ifndef SYNTHESIS
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff != 2'd3) else $error("queue count out of range");
   a_ptr_balance: assert property (@(posedge clock) disable iff (reset)
      (count_ff == 2'd1) |-> (wr_ptr_ff != rd_ptr_ff))
      else $error("queue pointers disagree with count");
   a_push_count: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> (count_ff == $past(count_ff) + 2'd1))
      else $error("push lost");
`endif

endmodule

FILE: design/ape_back.sv
// Back end: pulse-width frame sequencer, configuration registers and result register.
module ape_back (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_we,
   input  logic [ape_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [ape_pkg::REG_W-1:0]         csr_wdata,
   input  logic                              cmd_valid,
   output logic                              cmd_ready,
   input  ape_pkg::cmd_type                  cmd,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output ape_pkg::rsp_type                  rsp_data
);

   localparam int FB = ape_pkg::FRAME_BITS;
   localparam int PW = ape_pkg::POS_W;
   localparam int TW = ape_pkg::TIMER_WIDTH;

   logic [ape_pkg::REG_W-1:0]    start_ticks_ff, short_ticks_ff, long_ticks_ff;
   logic [ape_pkg::REPEAT_W-1:0] frame_repeats_ff;

   logic          sending_ff, sending_in;
   logic [FB-1:0] frame_word_ff, frame_word_in;
   logic [PW-1:0] bit_position_ff, bit_position_in;
   logic          second_half_ff, second_half_in;
   logic          in_start_pulse_ff, in_start_pulse_in;
   logic [ape_pkg::REPEAT_W-1:0] frames_left_ff, frames_left_in;
   logic [TW-1:0] segment_timer_ff, segment_timer_in;
   logic          level_ff, level_in;
   logic          rsp_valid_ff, rsp_valid_in;
   ape_pkg::rsp_type rsp_data_ff;

   logic          step, took, cur_bit, nxt_bit;
   logic [PW-1:0] pos_inc;
   logic [TW-1:0] timer_dec;
   logic [ape_pkg::REPEAT_W-1:0] frames_dec;

   function automatic logic bit_at(input logic [FB-1:0] word, input logic [PW-1:0] pos);
      logic [PW-1:0] idx;
      idx = PW'(FB - 1) - pos;
      return (pos < PW'(FB)) ? word[idx[$clog2(FB)-1:0]] : 1'b0;
   endfunction

   assign cmd_ready = !rsp_valid_ff || rsp_ready;
   assign step      = cmd_valid && cmd_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_comb begin
      sending_in        = sending_ff;
      frame_word_in     = frame_word_ff;
      bit_position_in   = bit_position_ff;
      second_half_in    = second_half_ff;
      in_start_pulse_in = in_start_pulse_ff;
      frames_left_in    = frames_left_ff;
      segment_timer_in  = segment_timer_ff;
      level_in          = level_ff;
      took              = 1'b0;
      cur_bit           = bit_at(frame_word_ff, bit_position_ff);
      pos_inc           = bit_position_ff + PW'(1);
      nxt_bit           = bit_at(frame_word_ff, pos_inc);
      timer_dec         = segment_timer_ff - TW'(1);
      frames_dec        = frames_left_ff - ape_pkg::REPEAT_W'(1);
      rsp_valid_in      = rsp_valid_ff && !rsp_ready;

      if (step) begin
         rsp_valid_in = 1'b1;
         if (cmd.is_start) begin
            if (!sending_ff) begin
               frame_word_in     = cmd.frame_word;
               frames_left_in    = (frame_repeats_ff == '0) ?
                                   ape_pkg::REPEAT_W'(1) : frame_repeats_ff;
               sending_in        = 1'b1;
               in_start_pulse_in = 1'b1;
               level_in          = 1'b1;
               bit_position_in   = '0;
               second_half_in    = 1'b0;
               segment_timer_in  = ape_pkg::duration(start_ticks_ff);
               took              = 1'b1;
            end
         end else if (sending_ff) begin
            segment_timer_in = timer_dec;
            if (timer_dec == '0) begin
               if (in_start_pulse_ff) begin
                  in_start_pulse_in = 1'b0;
                  bit_position_in   = '0;
                  second_half_in    = 1'b0;
                  level_in          = 1'b0;
                  segment_timer_in  = bit_at(frame_word_ff, '0) ?
                                      ape_pkg::duration(long_ticks_ff) :
                                      ape_pkg::duration(short_ticks_ff);
               end else if (!cur_bit && !second_half_ff) begin
                  second_half_in   = 1'b1;
                  level_in         = !level_ff;
                  segment_timer_in = ape_pkg::duration(short_ticks_ff);
               end else begin
                  second_half_in  = 1'b0;
                  bit_position_in = pos_inc;
                  if (pos_inc >= PW'(FB)) begin
                     frames_left_in = frames_dec;
                     if (frames_dec == '0) begin
                        sending_in       = 1'b0;
                        level_in         = 1'b0;
                        bit_position_in  = '0;
                        segment_timer_in = '0;
                     end else begin
                        in_start_pulse_in = 1'b1;
                        level_in          = 1'b1;
                        bit_position_in   = '0;
                        segment_timer_in  = ape_pkg::duration(start_ticks_ff);
                     end
                  end else begin
                     level_in         = !level_ff;
                     segment_timer_in = nxt_bit ? ape_pkg::duration(long_ticks_ff) :
                                                  ape_pkg::duration(short_ticks_ff);
                  end
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         rsp_data_ff.line_level <= level_in;
         rsp_data_ff.busy_res   <= sending_in;
         rsp_data_ff.accepted   <= took;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_ticks_ff    <= ape_pkg::START_TICKS_RESET;
         short_ticks_ff    <= ape_pkg::SHORT_TICKS_RESET;
         long_ticks_ff     <= ape_pkg::LONG_TICKS_RESET;
         frame_repeats_ff  <= ape_pkg::FRAME_REPEATS_RESET;
         sending_ff        <= 1'b0;
         frame_word_ff     <= '0;
         bit_position_ff   <= '0;
         second_half_ff    <= 1'b0;
         in_start_pulse_ff <= 1'b0;
         frames_left_ff    <= '0;
         segment_timer_ff  <= '0;
         level_ff          <= 1'b0;
         rsp_valid_ff      <= 1'b0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               ape_pkg::CSR_START_TICKS:   start_ticks_ff   <= csr_wdata;
               ape_pkg::CSR_SHORT_TICKS:   short_ticks_ff   <= csr_wdata;
               ape_pkg::CSR_LONG_TICKS:    long_ticks_ff    <= csr_wdata;
               ape_pkg::CSR_FRAME_REPEATS: frame_repeats_ff <= csr_wdata[ape_pkg::REPEAT_W-1:0];
               default: ;
            endcase
         end
         sending_ff        <= sending_in;
         frame_word_ff     <= frame_word_in;
         bit_position_ff   <= bit_position_in;
         second_half_ff    <= second_half_in;
         in_start_pulse_ff <= in_start_pulse_in;
         frames_left_ff    <= frames_left_in;
         segment_timer_ff  <= segment_timer_in;
         level_ff          <= level_in;
         rsp_valid_ff      <= rsp_valid_in;
      end
   end

`ifndef SYNTHESIS
   a_idle_low: assert property (@(posedge clock) disable iff (reset)
      !sending_ff |-> !level_ff) else $error("line high while idle");
   a_pulse_high: assert property (@(posedge clock) disable iff (reset)
      (sending_ff && in_start_pulse_ff) |-> level_ff) else $error("start pulse not high");
   a_pos_range: assert property (@(posedge clock) disable iff (reset)
      bit_position_ff < PW'(FB)) else $error("bit position out of range");
   a_frames_live: assert property (@(posedge clock) disable iff (reset)
      sending_ff |-> (frames_left_ff != '0)) else $error("sending with no frames left");
   a_start_taken: assert property (@(posedge clock) disable iff (reset)
      (step && cmd.is_start && !sending_ff) |=> (sending_ff && rsp_data_ff.accepted))
      else $error("start transaction not taken");
`endif

endmodule

FILE: test/alternating_pulse_remote_encoder_core_tb.sv
// Self-checking testbench for the alternating pulse remote encoder core.
module alternating_pulse_remote_encoder_core_tb;

   localparam int WATCHDOG_LIMIT       = 2000;
   localparam int FULL_RUN             = 1000000000;
   localparam ape_pkg::rsp_type RSP_IDLE  = 3'b000;
   localparam ape_pkg::rsp_type RSP_TAKEN = 3'b111;
   localparam ape_pkg::rsp_type RSP_HIGH  = 3'b110;

   typedef struct packed {
      logic             known;
      ape_pkg::rsp_type want;
   } fixed_result;

   typedef struct packed {
      logic             op;
      logic [15:0]      remote_id;
      logic [6:0]       keycode;
      logic [7:0]       count;
      logic             known;
      ape_pkg::rsp_type want;
   } script_row;

   logic                          clock     = 1'b0;
   logic                          reset     = 1'b1;
   logic                          req_valid = 1'b0;
   logic                          req_ready;
   ape_pkg::req_type              req_data  = '0;
   logic                          rsp_valid;
   logic                          rsp_ready = 1'b0;
   ape_pkg::rsp_type              rsp_data;
   logic                          csr_we    = 1'b0;
   logic [ape_pkg::CSR_IDX_W-1:0] csr_index = '0;
   logic [ape_pkg::REG_W-1:0]     csr_wdata = '0;

   // predicted transmitter state and timing registers
   logic                           tx_active;
   logic [ape_pkg::FRAME_BITS-1:0] tx_word;
   int                             tx_bit;
   logic                           tx_second_half;
   logic                           tx_lead;
   logic [7:0]                     tx_frames_left;
   logic [15:0]                    tx_timer;
   logic                           tx_level;
   logic [15:0]                    cfg_start, cfg_short, cfg_long;
   logic [7:0]                     cfg_repeats;

   ape_pkg::rsp_type pending_rsp [$];
   fixed_result      fixed_q [$];
   logic [15:0]      written_reg [4] = '{ape_pkg::START_TICKS_RESET,
                                         ape_pkg::SHORT_TICKS_RESET,
                                         ape_pkg::LONG_TICKS_RESET,
                                         16'(ape_pkg::FRAME_REPEATS_RESET)};
   logic        steady = 1'b0;
   int          mismatches = 0;
   int          items_sent = 0;
   int          results_checked = 0;
   int          codes_taken = 0;
   int          starts_ignored = 0;
   int          quiet_cycles = 0;

   script_row script_rows [7] = '{
      '{ape_pkg::OP_TICK,  16'h0000, 7'h00, 8'd1,  1'b1, RSP_IDLE},
      '{ape_pkg::OP_TICK,  16'hFFFF, 7'h7F, 8'd1,  1'b1, RSP_IDLE},
      '{ape_pkg::OP_START, 16'hFFFF, 7'h7F, 8'd1,  1'b1, RSP_TAKEN},
      '{ape_pkg::OP_START, 16'h0000, 7'h00, 8'd1,  1'b1, RSP_HIGH},
      '{ape_pkg::OP_TICK,  16'hA5A5, 7'h2A, 8'd23, 1'b0, RSP_IDLE},
      '{ape_pkg::OP_TICK,  16'h5A5A, 7'h55, 8'd1,  1'b1, RSP_IDLE},
      '{ape_pkg::OP_TICK,  16'h1234, 7'h3C, 8'd1,  1'b1, RSP_IDLE}
   };

   alternating_pulse_remote_encoder_core i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #4 clock = ~clock;

   function automatic logic [15:0] ticks_of(input logic [15:0] value);
      return (value == 16'd0) ? 16'd1 : value;
   endfunction

   function automatic logic bit_now();
      return tx_word[ape_pkg::FRAME_BITS-1-tx_bit];
   endfunction

   function automatic void open_frame();
      tx_lead        = 1'b1;
      tx_level       = 1'b1;
      tx_bit         = 0;
      tx_second_half = 1'b0;
      tx_timer       = ticks_of(cfg_start);
   endfunction

   function automatic void next_segment();
      if (tx_lead) begin
         tx_lead        = 1'b0;
         tx_bit         = 0;
         tx_second_half = 1'b0;
         tx_level       = 1'b0;
         tx_timer       = bit_now() ? ticks_of(cfg_long) : ticks_of(cfg_short);
      end else if (!bit_now() && !tx_second_half) begin
         tx_second_half = 1'b1;
         tx_level       = !tx_level;
         tx_timer       = ticks_of(cfg_short);
      end else begin
         tx_second_half = 1'b0;
         tx_bit++;
         if (tx_bit >= ape_pkg::FRAME_BITS) begin
            tx_frames_left = tx_frames_left - 8'd1;
            if (tx_frames_left == 8'd0) begin
               tx_active = 1'b0;
               tx_level  = 1'b0;
               tx_bit    = 0;
               tx_timer  = 16'd0;
            end else begin
               open_frame();
            end
         end else begin
            tx_level = !tx_level;
            tx_timer = bit_now() ? ticks_of(cfg_long) : ticks_of(cfg_short);
         end
      end
   endfunction

   function automatic ape_pkg::rsp_type predict_line(input ape_pkg::req_type item);
      ape_pkg::rsp_type r;
      logic             took;
      took = 1'b0;
      if (item.op == ape_pkg::OP_START) begin
         if (!tx_active) begin
            tx_word        = {item.remote_id, item.keycode};
            tx_frames_left = (cfg_repeats == 8'd0) ? 8'd1 : cfg_repeats;
            tx_active      = 1'b1;
            open_frame();
            took = 1'b1;
         end
      end else if (tx_active) begin
         tx_timer = tx_timer - 16'd1;
         if (tx_timer == 16'd0) next_segment();
      end
      r.line_level = tx_level;
      r.busy_res   = tx_active;
      r.accepted   = took;
      return r;
   endfunction

   function automatic void check_bit(input string name, input logic want, input logic got);
      if (got !== want) begin
         $error("%s: expected %0b, got %0b", name, want, got);
         mismatches++;
      end
   endfunction

   always @(posedge clock) begin
      ape_pkg::rsp_type want;
      fixed_result      hint;
      if (reset) begin
         tx_active      = 1'b0;
         tx_word        = '0;
         tx_bit         = 0;
         tx_second_half = 1'b0;
         tx_lead        = 1'b0;
         tx_frames_left = '0;
         tx_timer       = '0;
         tx_level       = 1'b0;
         cfg_start      = ape_pkg::START_TICKS_RESET;
         cfg_short      = ape_pkg::SHORT_TICKS_RESET;
         cfg_long       = ape_pkg::LONG_TICKS_RESET;
         cfg_repeats    = ape_pkg::FRAME_REPEATS_RESET;
         pending_rsp.delete();
      end else begin
         if (csr_we) begin
            case (csr_index)
               ape_pkg::CSR_START_TICKS:   cfg_start   = csr_wdata;
               ape_pkg::CSR_SHORT_TICKS:   cfg_short   = csr_wdata;
               ape_pkg::CSR_LONG_TICKS:    cfg_long    = csr_wdata;
               ape_pkg::CSR_FRAME_REPEATS: cfg_repeats = csr_wdata[7:0];
               default: ;
            endcase
         end
         if (rsp_valid && rsp_ready) begin
            results_checked++;
            if (pending_rsp.size() == 0) begin
               $error("result with nothing expected: %b", rsp_data);
               mismatches++;
            end else begin
               want = pending_rsp.pop_front();
               check_bit("line_level", want.line_level, rsp_data.line_level);
               check_bit("busy_res", want.busy_res, rsp_data.busy_res);
               check_bit("accepted", want.accepted, rsp_data.accepted);
            end
         end
         if (req_valid && req_ready) begin
            want = predict_line(req_data);
            if (req_data.op == ape_pkg::OP_START) begin
               if (want.accepted) codes_taken++;
               else starts_ignored++;
            end
            hint = fixed_q.pop_front();
            pending_rsp.push_back(hint.known ? hint.want : want);
         end
      end
   end

   always @(posedge clock) rsp_ready <= !reset && (steady || $urandom_range(99) >= 9);

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == WATCHDOG_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   task automatic send_item(input logic op, input logic [15:0] id, input logic [6:0] key,
                            input logic known, input ape_pkg::rsp_type want);
      fixed_result hint;
      if (!steady && $urandom_range(99) < 9) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(3, 1)) @(posedge clock);
      end
      hint.known = known;
      hint.want  = want;
      fixed_q.push_back(hint);
      req_valid <= 1'b1;
      req_data  <= '{op, id, key};
      do @(posedge clock); while (!req_ready);
      items_sent++;
   endtask

   task automatic send_tick();
      send_item(ape_pkg::OP_TICK, 16'($urandom), 7'($urandom), 1'b0, RSP_IDLE);
   endtask

   task automatic wait_quiet();
      req_valid <= 1'b0;
      while (pending_rsp.size() != 0) @(negedge clock);
      @(posedge clock);
   endtask

   task automatic write_reg(input logic [ape_pkg::CSR_IDX_W-1:0] idx,
                            input logic [15:0] value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      written_reg[idx] = value;
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_timing(input logic [15:0] lead, input logic [15:0] zero_half,
                             input logic [15:0] one_len, input logic [15:0] repeats);
      write_reg(ape_pkg::CSR_START_TICKS, lead);
      write_reg(ape_pkg::CSR_SHORT_TICKS, zero_half);
      write_reg(ape_pkg::CSR_LONG_TICKS, one_len);
      write_reg(ape_pkg::CSR_FRAME_REPEATS, repeats);
   endtask

   function automatic int code_ticks(input logic [15:0] id, input logic [6:0] key);
      logic [ape_pkg::FRAME_BITS-1:0] word;
      int                             per_frame;
      int                             reps;
      word      = {id, key};
      per_frame = int'(ticks_of(written_reg[ape_pkg::CSR_START_TICKS]));
      for (int b = 0; b < ape_pkg::FRAME_BITS; b++)
         per_frame += word[b] ? int'(ticks_of(written_reg[ape_pkg::CSR_LONG_TICKS]))
                              : 2 * int'(ticks_of(written_reg[ape_pkg::CSR_SHORT_TICKS]));
      reps = (written_reg[ape_pkg::CSR_FRAME_REPEATS][7:0] == 8'd0) ?
             1 : int'(written_reg[ape_pkg::CSR_FRAME_REPEATS][7:0]);
      return reps * per_frame;
   endfunction

   // start a code, then tick until the last frame ends or the cap is reached, with ignored starts mixed in
   task automatic play_code(input logic [15:0] id, input logic [6:0] key, input int cap);
      int remaining;
      remaining = code_ticks(id, key);
      if (remaining > cap) remaining = cap;
      send_item(ape_pkg::OP_START, id, key, 1'b0, RSP_IDLE);
      repeat (remaining) begin
         if ($urandom_range(99) < 4)
            send_item(ape_pkg::OP_START, 16'($urandom), 7'($urandom), 1'b0, RSP_IDLE);
         send_tick();
      end
   endtask

   function automatic logic [15:0] small_setting(input int hi);
      return ($urandom_range(9) == 0) ? 16'd0 : 16'($urandom_range(hi, 1));
   endfunction

   initial begin
      int random_base;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      set_timing(16'd1, 16'd1, 16'd1, 16'd1);
      foreach (script_rows[r])
         repeat (script_rows[r].count)
            send_item(script_rows[r].op, script_rows[r].remote_id, script_rows[r].keycode,
                      script_rows[r].known, script_rows[r].want);

      wait_quiet();
      set_timing(16'd0, 16'd0, 16'd0, 16'd0);
      play_code(16'($urandom), 7'($urandom), FULL_RUN);

      wait_quiet();
      set_timing(16'd2, 16'd1, 16'd2, 16'hAB02);
      play_code(16'($urandom), 7'($urandom), FULL_RUN);

      wait_quiet();
      steady = 1'b1;
      set_timing(16'd1, 16'd1, 16'd1, 16'd4);
      play_code(16'hFFFF, 7'h7F, FULL_RUN);
      wait_quiet();
      steady = 1'b0;

      random_base = items_sent;
      while (items_sent - random_base < 160) begin
         wait_quiet();
         set_timing(small_setting(2), small_setting(2), small_setting(3), small_setting(2));
         repeat ($urandom_range(2, 1)) begin
            repeat ($urandom_range(2)) send_tick();
            case ($urandom_range(9))
               0:       play_code(16'h0000, 7'h00, FULL_RUN);
               1:       play_code(16'hFFFF, 7'h7F, FULL_RUN);
               default: play_code(16'($urandom), 7'($urandom), FULL_RUN);
            endcase
         end
      end

      wait_quiet();
      set_timing(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h00FF);
      play_code(16'($urandom), 7'($urandom), 40);

      wait_quiet();
      repeat (8) @(posedge clock);
      if (pending_rsp.size() != 0) begin
         $error("%0d expected results never arrived", pending_rsp.size());
         mismatches++;
      end
      $display("run covered %0d requests and %0d checked results", items_sent, results_checked);
      $display("%0d codes sent, %0d starts dropped while busy", codes_taken, starts_ignored);
      if (mismatches == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
